>>> design/crsv_pkg.sv
// ----------------------------------------------------------------------------
// crsv_pkg
// Shared types, stage map and register codes of the streaming velocity core.
// ----------------------------------------------------------------------------
`default_nettype none

package crsv_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_STREAM_ON  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BOX_LENGTH = 8'd1;

   // stage map
   localparam int ST_MUL   = 1;
   localparam int ST_DOT   = 2;
   localparam int ST_FDIV  = 3;    // 31 steps, rho root runs in the first 24
   localparam int ST_SQR   = 34;
   localparam int ST_SUM   = 35;
   localparam int ST_ROOT  = 36;   // 32 steps
   localparam int ST_SINIT = 68;
   localparam int ST_SDIV  = 69;   // 31 steps
   localparam int ST_VMUL  = 100;
   localparam int ST_VINIT = 101;
   localparam int ST_VDIV  = 102;  // 31 steps
   localparam int ST_LAST  = 132;
   localparam int N_STG    = 133;

   localparam int QROOT_STEPS = 24;
   localparam int DIV_STEPS   = 31;
   localparam int ROOT_STEPS  = 32;

   typedef struct packed {
      logic              on;
      logic [30:0]       len;
      logic [31:0]       rho;
      logic [2:0][31:0]  b;
      logic [2:0][31:0]  g;
      logic [31:0]       energy;
      logic [2:0][63:0]  prod;
      logic [29:0]       e3;
      logic [34:0]       den10;
      logic [31:0]       d;
      logic [45:0]       fn;
      logic              fsat;
      logic [30:0]       fq;
      logic [47:0]       qv;
      logic [47:0]       qr;
      logic [62:0]       dd;
      logic [62:0]       ff;
      logic [63:0]       sv;
      logic [63:0]       sr;
      logic [61:0]       sn;
      logic [30:0]       sq;
      logic [2:0][47:0]  mm;
      logic [2:0]        vsat;
      logic [2:0][30:0]  vq;
   } stage_type;

endpackage

`default_nettype wire

>>> design/crsv_if.sv
// ----------------------------------------------------------------------------
// crsv interfaces
// Valid/ready channels for cell words, velocity words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface crsv_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] density;
   logic [31:0] field_x;
   logic [31:0] field_y;
   logic [31:0] field_z;
   logic [31:0] grad_x;
   logic [31:0] grad_y;
   logic [31:0] grad_z;
   logic [31:0] ray_energy;
   modport source (output valid, density, field_x, field_y, field_z,
                   grad_x, grad_y, grad_z, ray_energy, input ready);
   modport sink (input valid, density, field_x, field_y, field_z,
                 grad_x, grad_y, grad_z, ray_energy, output ready);
endinterface

interface crsv_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] vel_x;
   logic [31:0] vel_y;
   logic [31:0] vel_z;
   modport source (output valid, vel_x, vel_y, vel_z, input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, output ready);
endinterface

interface crsv_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/cosmic_ray_streaming_velocity_core.sv
// ----------------------------------------------------------------------------
// cosmic_ray_streaming_velocity_core
// Streaming velocity -B/sqrt(rho) * regularized sign of B.grad, Q16.16.
// ----------------------------------------------------------------------------
//  channel   direction  word
//  req_bus   in         density, field, gradient, ray energy of one cell
//  rsp_bus   out        vel_x, vel_y, vel_z
//  csr_bus   in         register index, write data (always ready)
//
//  One cell word per cycle, except while the output stall below holds the pipeline.
//  Pipeline depth is set by the bit-per-stage dividers and square roots.
//  Reset clears the stage valid bits and the output valid, sets stream on and box length 65536.
//  The whole pipeline holds while its last stage is full and the output word
//  is not taken; bubbles inside the pipeline do not close up.
`default_nettype none

module cosmic_ray_streaming_velocity_core (
   input  wire logic  clock,
   input  wire logic  reset,
   crsv_req_if.sink   req_bus,
   crsv_rsp_if.source rsp_bus,
   crsv_csr_if.sink   csr_bus
);
   import crsv_pkg::*;

   logic            on_ff;
   logic [30:0]     len_ff;
   stage_type       stg_ff [N_STG];
   stage_type       stg_in [N_STG];
   logic [N_STG-1:0] vld_ff;
   logic            adv;
   logic            rsp_valid_ff;
   logic [2:0][31:0] vel_ff;
   logic [2:0][31:0] vel_in;

   assign adv           = !(vld_ff[ST_LAST] && rsp_valid_ff && !rsp_bus.ready);
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.vel_x = vel_ff[0];
   assign rsp_bus.vel_y = vel_ff[1];
   assign rsp_bus.vel_z = vel_ff[2];

   always_comb begin
      stage_type x;
      logic signed [63:0] ps;
      logic signed [49:0] acc;
      logic [63:0] u64;
      logic [65:0] t66;
      logic [63:0] t64;
      logic [55:0] t56;
      logic [47:0] rb;
      logic [47:0] rt;
      logic [63:0] sb;
      logic [63:0] st;
      logic [31:0] ab;
      logic [30:0] ln;
      int i;
      int j;
      x   = '0;
      ps  = '0;
      acc = '0;
      u64 = '0;
      t66 = '0;
      t64 = '0;
      t56 = '0;
      rb  = '0;
      rt  = '0;
      sb  = '0;
      st  = '0;
      ab  = '0;
      ln  = '0;
      i   = 0;
      j   = 0;
      stg_in[0]        = '0;
      stg_in[0].on     = on_ff;
      stg_in[0].len    = len_ff;
      stg_in[0].rho    = req_bus.density;
      stg_in[0].b      = {req_bus.field_z, req_bus.field_y, req_bus.field_x};
      stg_in[0].g      = {req_bus.grad_z, req_bus.grad_y, req_bus.grad_x};
      stg_in[0].energy = req_bus.ray_energy;
      for (int k = 1; k < N_STG; k++) begin
         x = stg_ff[k-1];
         if (k == ST_MUL) begin
            for (int a = 0; a < 3; a++) begin
               ps = $signed(x.b[a]) * $signed(x.g[a]);
               x.prod[a] = ps;
            end
            if ($signed(x.energy) > 0) begin
               u64 = {32'b0, x.energy} * 64'h0AAAAAAAB;
               x.e3 = u64[62:33];
            end else begin
               x.e3 = '0;
            end
            if ($signed(x.rho) < 1) begin
               x.rho = 32'd1;
            end
            ln = (x.len == '0) ? 31'd1 : x.len;
            x.den10 = (35'(ln) << 3) + (35'(ln) << 1);
         end
         if (k == ST_DOT) begin
            acc = '0;
            for (int a = 0; a < 3; a++) begin
               ps = $signed(x.prod[a]);
               if (ps < 0) begin
                  ps = ps + 64'sd65535;
               end
               acc = acc + 50'(ps >>> 16);
            end
            if (acc > 50'sd2147483647) begin
               x.d = 32'h7FFF_FFFF;
            end else if (acc < -50'sd2147483648) begin
               x.d = 32'h8000_0000;
            end else begin
               x.d = acc[31:0];
            end
            x.fn   = {((x.e3 == '0) ? 30'd1 : x.e3), 16'b0};
            x.fsat = {20'b0, x.fn} >= {x.den10, 31'b0};
            x.fq   = '0;
            x.qv   = {1'b0, x.rho[30:0], 16'b0};
            x.qr   = '0;
         end
         if (k >= ST_FDIV && k < ST_FDIV + DIV_STEPS) begin
            i = ST_FDIV + DIV_STEPS - 1 - k;
            t66 = 66'(x.den10) << i;
            if ({20'b0, x.fn} >= t66) begin
               x.fn    = x.fn - t66[45:0];
               x.fq[i] = 1'b1;
            end
            j = k - ST_FDIV;
            if (j < QROOT_STEPS) begin
               rb = 48'd1 << (46 - 2 * j);
               rt = x.qr + rb;
               if (x.qv >= rt) begin
                  x.qv = x.qv - rt;
                  x.qr = (x.qr >> 1) + rb;
               end else begin
                  x.qr = x.qr >> 1;
               end
            end
         end
         if (k == ST_SQR) begin
            if (x.fsat) begin
               x.fq = 31'h7FFF_FFFF;
            end
            ps   = $signed(x.d) * $signed(x.d);
            x.dd = ps[62:0];
            u64  = {33'b0, x.fq} * {33'b0, x.fq};
            x.ff = u64[62:0];
         end
         if (k == ST_SUM) begin
            x.sv = {1'b0, x.dd} + {1'b0, x.ff} + 64'd65536;
            x.sr = '0;
         end
         if (k >= ST_ROOT && k < ST_ROOT + ROOT_STEPS) begin
            j  = k - ST_ROOT;
            sb = 64'd1 << (62 - 2 * j);
            st = x.sr + sb;
            if (x.sv >= st) begin
               x.sv = x.sv - st;
               x.sr = (x.sr >> 1) + sb;
            end else begin
               x.sr = x.sr >> 1;
            end
         end
         if (k == ST_SINIT) begin
            ab   = x.d[31] ? (32'd0 - x.d) : x.d;
            x.sn = {ab, 30'b0};
            x.sq = '0;
         end
         if (k >= ST_SDIV && k < ST_SDIV + DIV_STEPS) begin
            i = ST_SDIV + DIV_STEPS - 1 - k;
            t64 = 64'(x.sr[31:0]) << i;
            if ({2'b0, x.sn} >= t64) begin
               x.sn    = x.sn - t64[61:0];
               x.sq[i] = 1'b1;
            end
         end
         if (k == ST_VMUL) begin
            for (int a = 0; a < 3; a++) begin
               ab = x.b[a][31] ? (32'd0 - x.b[a]) : x.b[a];
               x.prod[a] = {32'b0, ab} * {33'b0, x.sq};
            end
         end
         if (k == ST_VINIT) begin
            for (int a = 0; a < 3; a++) begin
               x.mm[a]   = x.prod[a][61:14];
               x.vsat[a] = {8'b0, x.mm[a]} >= (56'(x.qr[23:0]) << 31);
               x.vq[a]   = '0;
            end
         end
         if (k >= ST_VDIV && k < ST_VDIV + DIV_STEPS) begin
            i = ST_VDIV + DIV_STEPS - 1 - k;
            t56 = 56'(x.qr[23:0]) << i;
            for (int a = 0; a < 3; a++) begin
               if ({8'b0, x.mm[a]} >= t56) begin
                  x.mm[a]    = x.mm[a] - t56[47:0];
                  x.vq[a][i] = 1'b1;
               end
            end
         end
         stg_in[k] = x;
      end
   end

   always_comb begin
      stage_type y;
      logic neg;
      y = stg_ff[ST_LAST];
      for (int a = 0; a < 3; a++) begin
         neg = !(y.b[a][31] ^ y.d[31]);
         if (!y.on) begin
            vel_in[a] = '0;
         end else if (y.vsat[a]) begin
            vel_in[a] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            vel_in[a] = neg ? (32'd0 - {1'b0, y.vq[a]}) : {1'b0, y.vq[a]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff        <= 1'b1;
         len_ff       <= 31'd65536;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_bus.index)
               REG_STREAM_ON:  on_ff  <= csr_bus.data[0];
               REG_BOX_LENGTH: len_ff <= csr_bus.data[30:0];
               default: ;
            endcase
         end
         if (adv) begin
            vld_ff <= {vld_ff[N_STG-2:0], req_bus.valid};
         end
         if (vld_ff[ST_LAST] && adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N_STG; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         if (vld_ff[ST_LAST]) begin
            vel_ff <= vel_in;
         end
      end
   end

   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_LAST] && rsp_valid_ff && !rsp_bus.ready |=> vld_ff[ST_LAST])
      else $error("last stage word dropped during stall");
   a_rho_root: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SQR] |-> stg_ff[ST_SQR].qr >= 48'd256)
      else $error("density root below floor");
   a_den_root: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SINIT] |-> stg_ff[ST_SINIT].sr >= 64'd256)
      else $error("sign denominator below floor");
   a_sign_mag: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_VMUL] |-> stg_ff[ST_VMUL].sq <= 31'h4000_0000)
      else $error("sign magnitude above one");

endmodule

`default_nettype wire

>>> tb/tb_cosmic_ray_streaming_velocity_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cosmic_ray_streaming_velocity_core
// Drives cell words with random gaps and a randomly stalling velocity sink.
// A scoreboard class predicts each velocity word in 64-bit integer
// arithmetic and compares it with the core's output in order. Register
// writes are made only while the pipeline is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cosmic_ray_streaming_velocity_core;
   import crsv_pkg::*;

   localparam int      WATCHDOG_LIMIT = 20000;
   localparam int      DRAIN_CYCLES   = 150;
   localparam longint  S32_MAX        = 64'sd2147483647;
   localparam longint  S32_MIN        = -64'sd2147483648;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = REG_BOX_LENGTH + 8'd1;

   typedef struct packed {
      logic [31:0] density;
      logic [31:0] field_x;
      logic [31:0] field_y;
      logic [31:0] field_z;
      logic [31:0] grad_x;
      logic [31:0] grad_y;
      logic [31:0] grad_z;
      logic [31:0] ray_energy;
   } cell_t;

   typedef struct packed {
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_z;
   } velocity_t;

   class velocity_scoreboard;
      velocity_t   pending_vel[$];
      int          errors;
      bit          stream_on;
      bit [30:0]   box_length;

      function new();
         errors     = 0;
         stream_on  = 1'b1;
         box_length = 31'd65536;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
         if (index == REG_STREAM_ON) stream_on = data[0];
         else if (index == REG_BOX_LENGTH) box_length = data[30:0];
      endfunction

      static function longint sat32(longint x);
         if (x > S32_MAX) return S32_MAX;
         if (x < S32_MIN) return S32_MIN;
         return x;
      endfunction

      static function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned root;
         longint unsigned bitpos;
         root   = 0;
         bitpos = 64'd1 << 62;
         while (bitpos > v) bitpos = bitpos >> 2;
         while (bitpos != 0) begin
            if (v >= root + bitpos) begin
               v    = v - (root + bitpos);
               root = (root >> 1) + bitpos;
            end else begin
               root = root >> 1;
            end
            bitpos = bitpos >> 2;
         end
         return root;
      endfunction

      function velocity_t streaming_velocity(cell_t c);
         longint    rho, q, d, pc, len, f, s, div, v;
         longint    b[3];
         longint    g[3];
         longint unsigned den;
         logic [31:0] vel[3];
         velocity_t r;
         b[0] = longint'($signed(c.field_x));
         b[1] = longint'($signed(c.field_y));
         b[2] = longint'($signed(c.field_z));
         g[0] = longint'($signed(c.grad_x));
         g[1] = longint'($signed(c.grad_y));
         g[2] = longint'($signed(c.grad_z));
         if (!stream_on) return '0;
         rho = longint'($signed(c.density));
         if (rho < 1) rho = 1;
         q = longint'(int_sqrt(longint'(rho * 65536)));
         d = 0;
         for (int i = 0; i < 3; i++) d += (b[i] * g[i]) / 64'sd65536;
         d = sat32(d);
         pc = longint'($signed(c.ray_energy)) / 64'sd3;
         if (pc < 1) pc = 1;
         len = longint'(box_length);
         if (len == 0) len = 1;
         f = (pc * 64'sd65536) / (64'sd10 * len);
         if (f > S32_MAX) f = S32_MAX;
         den = int_sqrt(longint'(d * d) + longint'(f * f) + 64'd65536);
         s   = (d * (64'sd1 <<< 30)) / longint'(den);
         div = q * 64'sd16384;
         for (int i = 0; i < 3; i++) begin
            v      = -((b[i] * s) / div);
            vel[i] = 32'(sat32(v));
         end
         r.vel_x = vel[0];
         r.vel_y = vel[1];
         r.vel_z = vel[2];
         return r;
      endfunction

      function void note_cell(cell_t c);
         pending_vel = {pending_vel, streaming_velocity(c)};
      endfunction

      function void check_velocity(velocity_t got);
         velocity_t want;
         if (pending_vel.size() == 0) begin
            $display("%0t: unexpected velocity word %h %h %h", $time,
                     got.vel_x, got.vel_y, got.vel_z);
            errors++;
            return;
         end
         want = pending_vel.pop_front();
         if (got.vel_x !== want.vel_x) begin
            $display("%0t: vel_x expected %h actual %h", $time, want.vel_x, got.vel_x);
            errors++;
         end
         if (got.vel_y !== want.vel_y) begin
            $display("%0t: vel_y expected %h actual %h", $time, want.vel_y, got.vel_y);
            errors++;
         end
         if (got.vel_z !== want.vel_z) begin
            $display("%0t: vel_z expected %h actual %h", $time, want.vel_z, got.vel_z);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_cycles;
   bit   no_gaps;

   crsv_req_if req_bus ();
   crsv_rsp_if rsp_bus ();
   crsv_csr_if csr_bus ();

   velocity_scoreboard velocity_sb = new();

   cosmic_ray_streaming_velocity_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] rand_q16();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: begin
            return $urandom;
         end
         4, 5, 6: begin
            return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         end
         7: begin
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000 + 32'h0001_0000;
         end
         8: begin
            case ($urandom_range(0, 4))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'hFFFF_FFFF;
               3: return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
         default: begin
            return $signed($urandom) >>> $urandom_range(0, 31);
         end
      endcase
   endfunction

   function automatic cell_t rand_cell();
      cell_t c;
      c.density    = rand_q16();
      c.field_x    = rand_q16();
      c.field_y    = rand_q16();
      c.field_z    = rand_q16();
      c.grad_x     = rand_q16();
      c.grad_y     = rand_q16();
      c.grad_z     = rand_q16();
      c.ray_energy = rand_q16();
      return c;
   endfunction

   task automatic send_cell(cell_t c);
      int gap;
      req_bus.valid      <= 1'b1;
      req_bus.density    <= c.density;
      req_bus.field_x    <= c.field_x;
      req_bus.field_y    <= c.field_y;
      req_bus.field_z    <= c.field_z;
      req_bus.grad_x     <= c.grad_x;
      req_bus.grad_y     <= c.grad_y;
      req_bus.grad_z     <= c.grad_z;
      req_bus.ray_energy <= c.ray_energy;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      velocity_sb.note_cell(c);
      gap = gap_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      velocity_sb.write_reg(index, data);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (velocity_sb.pending_vel.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send_cell(rand_cell());
      end
      no_gaps = 1'b0;
   endtask

   task automatic run_directed();
      cell_t c;
      logic [31:0] ext[5];
      ext[0] = 32'h0000_0000;
      ext[1] = 32'h7FFF_FFFF;
      ext[2] = 32'h8000_0000;
      ext[3] = 32'hFFFF_FFFF;
      ext[4] = 32'h0001_0000;
      // uniform extremes on every field
      for (int i = 0; i < 5; i++) begin
         c = {8{ext[i]}};
         send_cell(c);
      end
      // unit cell, field along gradient and against it
      c = '{32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0003_0000};
      send_cell(c);
      c.grad_x = 32'hFFFF_0000;
      send_cell(c);
      // non-positive density, floored
      c.density = 32'h8000_0000;
      send_cell(c);
      c.density = 32'h0000_0000;
      send_cell(c);
      // non-positive and tiny energy, floored, then maximum energy
      c.density    = 32'h0001_0000;
      c.ray_energy = 32'h8000_0000;
      send_cell(c);
      c.ray_energy = 32'h0000_0002;
      send_cell(c);
      c.ray_energy = 32'h7FFF_FFFF;
      send_cell(c);
      // saturating gradient product
      c = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000};
      send_cell(c);
      c.grad_x = 32'h8000_0000;
      c.grad_y = 32'h8000_0000;
      c.grad_z = 32'h8000_0000;
      send_cell(c);
      // velocity overflow: strong field, thin gas
      c.density = 32'h0000_0001;
      c.field_y = 32'h8000_0000;
      send_cell(c);
      c.field_x = 32'h8000_0000;
      c.grad_x  = 32'h7FFF_FFFF;
      send_cell(c);
      // gradient orthogonal to field, sign near zero
      c = '{32'h0004_0000, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 32'h0000_3000};
      send_cell(c);
      // small dot product against the floor
      c = '{32'h0000_8000, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080,
            32'h0000_0100, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0003};
      send_cell(c);
      c.ray_energy = 32'h0100_0000;
      send_cell(c);
      req_bus.valid <= 1'b0;
   endtask

   // velocity sink: ready in runs, stalls of random length
   initial begin
      int len;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         len = $urandom_range(1, 40);
         repeat (len) @(posedge clock);
         len = gap_length();
         if (len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         velocity_sb.check_velocity({rsp_bus.vel_x, rsp_bus.vel_y, rsp_bus.vel_z});
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("cosmic_ray_streaming_velocity_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      no_gaps            = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.density    = '0;
      req_bus.field_x    = '0;
      req_bus.field_y    = '0;
      req_bus.field_z    = '0;
      req_bus.grad_x     = '0;
      req_bus.grad_y     = '0;
      req_bus.grad_z     = '0;
      req_bus.ray_energy = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(150);
      drain();

      write_csr(REG_BOX_LENGTH, 32'h0000_0001);
      run_directed();
      run_random(130);
      drain();

      write_csr(REG_BOX_LENGTH, 32'h7FFF_FFFF);
      run_random(150);
      drain();

      // zero length, and excess data bit masked
      write_csr(REG_BOX_LENGTH, 32'h8000_0000);
      run_random(120);
      drain();

      write_csr(REG_STREAM_ON, 32'h0000_0000);
      run_directed();
      run_random(100);
      drain();

      // out-of-range index is dropped
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);
      write_csr(REG_STREAM_ON, 32'hFFFF_FFFE);
      run_random(60);
      drain();

      write_csr(REG_STREAM_ON, 32'h0000_0001);
      write_csr(REG_BOX_LENGTH, {1'b0, 31'($urandom_range(1, 32'h0100_0000))});
      run_random(150);
      drain();

      write_csr(REG_BOX_LENGTH, 32'h0000_4000);
      run_random(150);
      drain();

      write_csr(REG_BOX_LENGTH, 32'h0001_0000);
      run_random(150);
      drain();

      if (velocity_sb.errors == 0 && velocity_sb.pending_vel.size() == 0) begin
         $display("cosmic_ray_streaming_velocity_core test passed");
      end else begin
         $display("cosmic_ray_streaming_velocity_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
